// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. The assertions use the clk and rst_n
// of the module that uses them. Synthesis sees empty macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Plain property checked at every edge outside reset
`define FMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Overlapping implication checked at every edge outside reset
`define FMD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define FMD_ASSERT(lbl, prop, msg)
`define FMD_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/fmd_pkg.sv
// ----------------------------------------------------------------------------
// fmd_pkg
// Types, widths and codes of the fuzzy membership / defuzzifier engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fmd_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  // Field widths
  localparam int MEMB_W     = 16;
  localparam int X_W        = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;

  localparam logic [MEMB_W-1:0] ONE_Q15 = 16'h8000;

  // Divider: quotient bits per divide, dividend and divisor widths
  localparam int QBITS  = 17;
  localparam int QCNT_W = $clog2(QBITS);
  localparam int NUM_W  = 32 + IDX_W;
  localparam int DVD_W  = NUM_W - 1;
  localparam int DSR_W  = 16 + IDX_W;
  localparam int ACC_W  = QBITS + 1;

  // Request codes
  localparam logic [1:0] REQ_EVAL   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_DEFUZZ = 2'd2;

  // Shape codes
  localparam logic [1:0] SHAPE_SINGLETON = 2'd0;
  localparam logic [1:0] SHAPE_TRIANGLE  = 2'd1;
  localparam logic [1:0] SHAPE_TRAPEZOID = 2'd2;
  localparam logic [1:0] SHAPE_TABLE     = 2'd3;

  // Defuzzify methods
  localparam logic METHOD_FIRST_MAX = 1'b0;
  localparam logic METHOD_COG       = 1'b1;

  // Register indexes
  localparam logic [2:0] REG_SHAPE_TYPE   = 3'd0;
  localparam logic [2:0] REG_PARAM_A      = 3'd1;
  localparam logic [2:0] REG_PARAM_B      = 3'd2;
  localparam logic [2:0] REG_PARAM_C      = 3'd3;
  localparam logic [2:0] REG_PARAM_D      = 3'd4;
  localparam logic [2:0] REG_RANGE_LOW    = 3'd5;
  localparam logic [2:0] REG_RANGE_HIGH   = 3'd6;
  localparam logic [2:0] REG_SAMPLE_COUNT = 3'd7;

  typedef struct packed {
    logic [1:0]         shape_type;
    logic signed [15:0] param_a;
    logic signed [15:0] param_b;
    logic [14:0]        param_c;
    logic [14:0]        param_d;
    logic signed [15:0] range_low;
    logic signed [15:0] range_high;
    logic [8:0]         sample_count;
  } cfg_regs_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [QBITS:0]   quo;
    logic [DSR_W-1:0]        rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EV_START,
    ST_EV_DIV,
    ST_EV_TDIV,
    ST_EV_RD,
    ST_EV_RES,
    ST_DF_SPAN,
    ST_DF_SAMPLE,
    ST_DF_ACC,
    ST_DF_END,
    ST_DF_CDIV,
    ST_DONE
  } fmd_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/fuzzy_membership_defuzzifier_core.sv
// To out_tvalid: write and unused requests go straight to ST_DONE; singleton, plateau
//   and out-of-support points skip the divider; slopes use the 17-step divider; table
//   lookups divide for the index unless span is zero. Defuzzify: span divide, then per
//   sample a table read or shape evaluation; centre of gravity with mass divides last.
// One item at a time; the next item is taken while a result waits in the output register.
// Reset: synchronous, active low; table valid bits clear together, no sweep.
// ----------------------------------------------------------------------------
// fuzzy_membership_defuzzifier_core
// Fuzzy set engine: membership evaluation, table writes and first maximum or
// centre of gravity defuzzification over a parametric shape or a RAM table.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fuzzy_membership_defuzzifier_core import fmd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] sample_x, [23:16] entry_index, [39:24] entry_value,
  // [40] defuzz_method, [47:41] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] membership, [31:16] crisp_x
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] no_mass
  output logic                  out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  cfg_regs_t regs;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  // Input transaction fields
  logic [1:0]               in_req;
  logic signed [X_W-1:0]    in_x;
  logic [7:0]               in_idx;
  logic [MEMB_W-1:0]        in_val;
  logic                     in_method;
  logic                     in_acc;

  assign in_req    = in_tuser;
  assign in_x      = in_tdata[15:0];
  assign in_idx    = in_tdata[23:16];
  assign in_val    = in_tdata[39:24];
  assign in_method = in_tdata[40];

  // Registers
  fmd_state_t               state_r, state_nxt;
  logic [1:0]               req_r, req_nxt;
  logic                     method_r, method_nxt;
  logic signed [X_W-1:0]    x_cur_r, x_cur_nxt;
  logic [MEMB_W-1:0]        m_r, m_nxt;
  logic signed [32:0]       prod_r, prod_nxt;
  logic [IDX_W-1:0]         smp_r, smp_nxt;
  logic signed [ACC_W-1:0]  qacc_r, qacc_nxt;
  logic [CNT_W-1:0]         racc_r, racc_nxt;
  logic signed [ACC_W-1:0]  qs_r, qs_nxt;
  logic [CNT_W-1:0]         rs_r, rs_nxt;
  logic [MEMB_W-1:0]        best_r, best_nxt;
  logic signed [X_W-1:0]    xbest_r, xbest_nxt;
  logic signed [NUM_W-1:0]  num_r, num_nxt;
  logic [DSR_W-1:0]         den_r, den_nxt;
  logic [MEMB_W-1:0]        res_memb_r, res_memb_nxt;
  logic signed [X_W-1:0]    res_crisp_r, res_crisp_nxt;
  logic                     res_flag_r, res_flag_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [MEMB_W-1:0]        out_memb_r, out_memb_nxt;
  logic signed [X_W-1:0]    out_crisp_r, out_crisp_nxt;
  logic                     out_flag_r, out_flag_nxt;
  logic [TABLE_DEPTH-1:0]   vld_r;
  logic                     vld_rd_r;

  // RAM port
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [MEMB_W-1:0]        ram_wdata;
  logic [IDX_W-1:0]         ram_raddr;
  logic [MEMB_W-1:0]        ram_rdata;

  // Derived configuration
  logic [CNT_W-1:0]         n_eff;
  logic [IDX_W-1:0]         n_m1;
  logic signed [16:0]       span;
  logic signed [16:0]       span_abs;
  logic signed [X_W-1:0]    p_a, p_b, r_lo, r_hi;

  // Shape arithmetic
  logic signed [18:0]       xe, ae, be, ce, de, dx, dx_abs, tnum, lo_e, hi_e, lnum, rnum;
  logic [15:0]              xoff;
  logic [MEMB_W-1:0]        sgl_h;
  logic signed [ACC_W-1:0]  xi;
  logic [CNT_W:0]           racc_sum;
  logic                     wrap;
  logic [CNT_W-1:0]         tq;
  logic signed [NUM_W-1:0]  num_abs;
  logic [MEMB_W-1:0]        wval_sat;

  fmd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (regs)
  );

  fmd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  fmd_ram #(.WIDTH(MEMB_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Effective sample count: zero counts as one, saturated to the table depth
  always_comb begin
    if (regs.sample_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(regs.sample_count) > TABLE_DEPTH) begin
      n_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      n_eff = CNT_W'(regs.sample_count);
    end
  end
  assign n_m1 = IDX_W'(n_eff - 1'b1);

  assign p_a      = regs.param_a;
  assign p_b      = regs.param_b;
  assign r_lo     = regs.range_low;
  assign r_hi     = regs.range_high;
  assign span     = 17'(r_hi) - 17'(r_lo);
  assign span_abs = (span < 0) ? -span : span;

  // Shape terms at the current point
  assign xe     = 19'(x_cur_r);
  assign ae     = 19'(p_a);
  assign be     = 19'(p_b);
  assign ce     = $signed({4'b0, regs.param_c});
  assign de     = $signed({4'b0, regs.param_d});
  assign dx     = xe - ae;
  assign dx_abs = (dx < 0) ? -dx : dx;
  assign tnum   = be - (dx_abs <<< 1);
  assign lo_e   = ae - ce;
  assign hi_e   = be + de;
  assign lnum   = ce + dx;
  assign rnum   = de - xe + be;
  assign xoff   = 16'(xe - 19'(r_lo));

  // Singleton height, Q8.8 to Q1.15 with saturation
  always_comb begin
    if (p_b < 0) begin
      sgl_h = '0;
    end else if (p_b >= 16'sd256) begin
      sgl_h = ONE_Q15;
    end else begin
      sgl_h = {p_b[8:0], 7'b0};
    end
  end

  // Sample walk: x_i = lo + floor(i*span/N) kept as quotient and remainder
  assign xi       = ACC_W'(r_lo) + qacc_r;
  assign racc_sum = {1'b0, racc_r} + {1'b0, rs_r};
  assign wrap     = racc_sum >= {1'b0, n_eff};

  assign tq       = div_rsp.quo[CNT_W-1:0];
  assign num_abs  = num_r[NUM_W-1] ? -num_r : num_r;
  assign wval_sat = (in_val > ONE_Q15) ? ONE_Q15 : in_val;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;

  // Next state and datapath
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    method_nxt    = method_r;
    x_cur_nxt     = x_cur_r;
    m_nxt         = m_r;
    prod_nxt      = prod_r;
    smp_nxt       = smp_r;
    qacc_nxt      = qacc_r;
    racc_nxt      = racc_r;
    qs_nxt        = qs_r;
    rs_nxt        = rs_r;
    best_nxt      = best_r;
    xbest_nxt     = xbest_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    res_memb_nxt  = res_memb_r;
    res_crisp_nxt = res_crisp_r;
    res_flag_nxt  = res_flag_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_memb_nxt  = out_memb_r;
    out_crisp_nxt = out_crisp_r;
    out_flag_nxt  = out_flag_r;
    div_req       = '0;
    ram_we        = 1'b0;
    ram_waddr     = IDX_W'(in_idx);
    ram_wdata     = wval_sat;
    ram_raddr     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt       = in_req;
          method_nxt    = in_method;
          x_cur_nxt     = in_x;
          res_memb_nxt  = '0;
          res_crisp_nxt = '0;
          res_flag_nxt  = 1'b0;
          case (in_req)
            REQ_EVAL: begin
              state_nxt = ST_EV_START;
            end
            REQ_WRITE: begin
              if ((regs.shape_type == SHAPE_TABLE) && (32'(in_idx) < 32'(n_eff))) begin
                ram_we = 1'b1;
              end
              state_nxt = ST_DONE;
            end
            REQ_DEFUZZ: begin
              // Step of the sample walk: span / N
              div_req.start    = 1'b1;
              div_req.neg      = span < 0;
              div_req.dividend = DVD_W'($unsigned(span_abs));
              div_req.divisor  = DSR_W'(n_eff);
              state_nxt        = ST_DF_SPAN;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // Evaluate the shape at x_cur
      ST_EV_START: begin
        m_nxt     = '0;
        state_nxt = ST_EV_RES;
        case (regs.shape_type)
          SHAPE_SINGLETON: begin
            if (x_cur_r == p_a) begin
              m_nxt = sgl_h;
            end
          end
          SHAPE_TRIANGLE: begin
            if ((p_b > 0) && (tnum > 0)) begin
              div_req.start    = 1'b1;
              div_req.dividend = DVD_W'({tnum[14:0], 15'b0});
              div_req.divisor  = DSR_W'(p_b[14:0]);
              state_nxt        = ST_EV_DIV;
            end
          end
          SHAPE_TRAPEZOID: begin
            if ((xe >= lo_e) && (xe < hi_e)) begin
              if (xe < ae) begin
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'({lnum[14:0], 15'b0});
                div_req.divisor  = DSR_W'(regs.param_c);
                state_nxt        = ST_EV_DIV;
              end else if (xe < be) begin
                m_nxt = ONE_Q15;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'({rnum[14:0], 15'b0});
                div_req.divisor  = DSR_W'(regs.param_d);
                state_nxt        = ST_EV_DIV;
              end
            end
          end
          default: begin
            if ((x_cur_r >= r_lo) && (x_cur_r <= r_hi)) begin
              if (r_hi > r_lo) begin
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'(n_eff * xoff);
                div_req.divisor  = DSR_W'(span[15:0]);
                state_nxt        = ST_EV_TDIV;
              end else begin
                ram_raddr = '0;
                state_nxt = ST_EV_RD;
              end
            end
          end
        endcase
      end

      ST_EV_DIV: begin
        if (div_rsp.done) begin
          m_nxt     = div_rsp.quo[MEMB_W-1:0];
          state_nxt = ST_EV_RES;
        end
      end

      // Table index, clamped to the last entry
      ST_EV_TDIV: begin
        if (div_rsp.done) begin
          ram_raddr = (tq >= n_eff) ? n_m1 : tq[IDX_W-1:0];
          state_nxt = ST_EV_RD;
        end
      end

      // Entries never written read as zero
      ST_EV_RD: begin
        m_nxt     = vld_rd_r ? ram_rdata : '0;
        state_nxt = ST_EV_RES;
      end

      ST_EV_RES: begin
        if (req_r == REQ_DEFUZZ) begin
          prod_nxt  = x_cur_r * $signed({1'b0, m_r});
          state_nxt = ST_DF_ACC;
        end else begin
          res_memb_nxt = m_r;
          state_nxt    = ST_DONE;
        end
      end

      ST_DF_SPAN: begin
        if (div_rsp.done) begin
          qs_nxt    = div_rsp.quo;
          rs_nxt    = div_rsp.rem[CNT_W-1:0];
          smp_nxt   = '0;
          qacc_nxt  = '0;
          racc_nxt  = '0;
          best_nxt  = '0;
          xbest_nxt = r_lo;
          num_nxt   = '0;
          den_nxt   = '0;
          state_nxt = ST_DF_SAMPLE;
        end
      end

      ST_DF_SAMPLE: begin
        x_cur_nxt = xi[X_W-1:0];
        if (regs.shape_type == SHAPE_TABLE) begin
          ram_raddr = smp_r;
          state_nxt = ST_EV_RD;
        end else begin
          state_nxt = ST_EV_START;
        end
      end

      // Accumulate one sample and advance the walk
      ST_DF_ACC: begin
        num_nxt = num_r + NUM_W'(prod_r);
        den_nxt = den_r + DSR_W'(m_r);
        if (m_r > best_r) begin
          best_nxt  = m_r;
          xbest_nxt = x_cur_r;
        end
        racc_nxt = wrap ? CNT_W'(racc_sum - {1'b0, n_eff}) : racc_sum[CNT_W-1:0];
        qacc_nxt = qacc_r + qs_r + $signed({{(ACC_W-1){1'b0}}, wrap});
        if (smp_r == n_m1) begin
          state_nxt = ST_DF_END;
        end else begin
          smp_nxt   = smp_r + 1'b1;
          state_nxt = ST_DF_SAMPLE;
        end
      end

      ST_DF_END: begin
        if (method_r == METHOD_FIRST_MAX) begin
          res_crisp_nxt = xbest_r;
          state_nxt     = ST_DONE;
        end else if (den_r == '0) begin
          res_flag_nxt = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.neg      = num_r[NUM_W-1];
          div_req.dividend = num_abs[DVD_W-1:0];
          div_req.divisor  = den_r;
          state_nxt        = ST_DF_CDIV;
        end
      end

      ST_DF_CDIV: begin
        if (div_rsp.done) begin
          res_crisp_nxt = div_rsp.quo[X_W-1:0];
          state_nxt     = ST_DONE;
        end
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_memb_nxt  = res_memb_r;
          out_crisp_nxt = res_crisp_r;
          out_flag_nxt  = res_flag_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // Datapath registers; valid bit read tracks the RAM read latency
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    method_r    <= method_nxt;
    x_cur_r     <= x_cur_nxt;
    m_r         <= m_nxt;
    prod_r      <= prod_nxt;
    smp_r       <= smp_nxt;
    qacc_r      <= qacc_nxt;
    racc_r      <= racc_nxt;
    qs_r        <= qs_nxt;
    rs_r        <= rs_nxt;
    best_r      <= best_nxt;
    xbest_r     <= xbest_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    res_memb_r  <= res_memb_nxt;
    res_crisp_r <= res_crisp_nxt;
    res_flag_r  <= res_flag_nxt;
    out_memb_r  <= out_memb_nxt;
    out_crisp_r <= out_crisp_nxt;
    out_flag_r  <= out_flag_nxt;
    vld_rd_r    <= vld_r[ram_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_crisp_r, out_memb_r};
  assign out_tuser  = out_flag_r;

  // Checks
  `FMD_ASSERT_IMPL(a_div_idle, in_tready, !div_rsp.busy, "divider busy while taking a transaction")
  `FMD_ASSERT_IMPL(a_div_done_wait, div_rsp.done, (state_r == ST_EV_DIV) || (state_r == ST_EV_TDIV) || (state_r == ST_DF_SPAN) || (state_r == ST_DF_CDIV), "divider result with nobody waiting")
  `FMD_ASSERT_IMPL(a_we_on_write, ram_we, in_tvalid && in_tready && (in_req == REQ_WRITE), "table write outside a write transaction")
  `FMD_ASSERT(a_start_idle, !(div_req.start && div_rsp.busy), "divider started while busy")

endmodule

`default_nettype wire

// File: hw/rtl/fmd_ram.sv
// ----------------------------------------------------------------------------
// fmd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hw/rtl/fmd_cfg.sv
// ----------------------------------------------------------------------------
// fmd_cfg
// APB register file holding shape, range and sample count settings.
// ----------------------------------------------------------------------------
`default_nettype none

module fmd_cfg import fmd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_regs_t         regs
);

  cfg_regs_t  regs_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.shape_type   <= SHAPE_TRIANGLE;
      regs_r.param_a      <= 16'sd0;
      regs_r.param_b      <= 16'sd256;
      regs_r.param_c      <= 15'd256;
      regs_r.param_d      <= 15'd256;
      regs_r.range_low    <= -16'sd256;
      regs_r.range_high   <= 16'sd256;
      regs_r.sample_count <= 9'd256;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SHAPE_TYPE:   regs_r.shape_type   <= pwdata[1:0];
        REG_PARAM_A:      regs_r.param_a      <= pwdata[15:0];
        REG_PARAM_B:      regs_r.param_b      <= pwdata[15:0];
        REG_PARAM_C:      regs_r.param_c      <= pwdata[14:0];
        REG_PARAM_D:      regs_r.param_d      <= pwdata[14:0];
        REG_RANGE_LOW:    regs_r.range_low    <= pwdata[15:0];
        REG_RANGE_HIGH:   regs_r.range_high   <= pwdata[15:0];
        REG_SAMPLE_COUNT: regs_r.sample_count <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Read back, signed registers sign extended
  always_comb begin
    unique case (reg_idx)
      REG_SHAPE_TYPE:   prdata = CFG_DW'(regs_r.shape_type);
      REG_PARAM_A:      prdata = CFG_DW'(regs_r.param_a);
      REG_PARAM_B:      prdata = CFG_DW'(regs_r.param_b);
      REG_PARAM_C:      prdata = CFG_DW'(regs_r.param_c);
      REG_PARAM_D:      prdata = CFG_DW'(regs_r.param_d);
      REG_RANGE_LOW:    prdata = CFG_DW'(regs_r.range_low);
      REG_RANGE_HIGH:   prdata = CFG_DW'(regs_r.range_high);
      REG_SAMPLE_COUNT: prdata = CFG_DW'(regs_r.sample_count);
      default:          prdata = '0;
    endcase
  end

  assign regs = regs_r;

endmodule

`default_nettype wire

// File: hw/rtl/fmd_div.sv
// ----------------------------------------------------------------------------
// fmd_div
// Restoring divider, one quotient bit per cycle, floor result for a signed
// dividend given as sign and magnitude. Remainder is always non-negative.
// ----------------------------------------------------------------------------
`default_nettype none

module fmd_div import fmd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [DSR_W-1:0]  rem_r;
  logic [QBITS-1:0]  quo_r;
  logic              neg_r;
  logic [DSR_W-1:0]  dsr_r;

  logic [DSR_W:0]    trial;
  logic              fit;
  logic signed [QBITS:0] q_mag;

  // One trial subtraction per cycle
  assign trial = {rem_r, quo_r[QBITS-1]};
  assign fit   = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= QCNT_W'(QBITS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= DSR_W'(req.dividend[DVD_W-1:QBITS]);
      quo_r <= req.dividend[QBITS-1:0];
      neg_r <= req.neg;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fit ? DSR_W'(trial - {1'b0, dsr_r}) : trial[DSR_W-1:0];
      quo_r <= {quo_r[QBITS-2:0], fit};
    end
  end

  // Floor correction for a negative dividend
  assign q_mag = $signed({1'b0, quo_r});

  always_comb begin
    rsp.busy = busy_r;
    rsp.done = done_r;
    if (neg_r && (rem_r != '0)) begin
      // -(q + 1) is the bitwise complement of q
      rsp.quo = ~q_mag;
      rsp.rem = dsr_r - rem_r;
    end else if (neg_r) begin
      rsp.quo = -q_mag;
      rsp.rem = '0;
    end else begin
      rsp.quo = q_mag;
      rsp.rem = rem_r;
    end
  end

endmodule

`default_nettype wire

// File: bench/fuzzy_membership_defuzzifier_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fuzzy_membership_defuzzifier_core_tb
// Stream-level bench for the fuzzy membership / defuzzifier engine. Directed
// items hit the field extremes and the corner cases. Randomized phases then
// follow, each with fresh register settings. An in-bench membership and
// defuzzify predictor checks every result transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_membership_defuzzifier_core_tb;
  import fmd_pkg::*;

  typedef struct {
    logic [1:0]         req;
    logic signed [15:0] x;
    logic [7:0]         idx;
    logic [15:0]        val;
    logic               method;
  } fuzzy_req_t;

  typedef struct {
    logic [15:0] memb;
    logic [15:0] crisp;
    logic        no_mass;
  } fuzzy_rsp_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr = '0;
  logic [CFG_DW-1:0]     cfg_pwdata = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  fuzzy_membership_defuzzifier_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always #4 clk = ~clk;

  // Predictor state
  cfg_regs_t   shadow_cfg;
  logic [15:0] shadow_table [TABLE_DEPTH];

  fuzzy_req_t  pending_items [$];
  fuzzy_rsp_t  expected_results [$];
  fuzzy_req_t  on_bus;
  int          items_taken = 0;
  int          results_seen = 0;
  int          error_count = 0;
  int          defuzz_count = 0;
  int          hold_left = 0;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 40)
      $display("%0t MISMATCH result %0d: %s", $time, results_seen, what);
  endtask

  // ---------------------------------------------------------------- predictor
  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint eff_samples();
    longint n;
    n = longint'(shadow_cfg.sample_count);
    if (n < 1) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  function automatic longint sample_abscissa(input longint k);
    longint lo, hi;
    lo = longint'($signed(shadow_cfg.range_low));
    hi = longint'($signed(shadow_cfg.range_high));
    return lo + floor_quot(k * (hi - lo), eff_samples());
  endfunction

  function automatic longint shape_membership(input longint x);
    longint a, b, c, d, lo, hi, dx_abs, num, h, k;
    a  = longint'($signed(shadow_cfg.param_a));
    b  = longint'($signed(shadow_cfg.param_b));
    c  = longint'(shadow_cfg.param_c);
    d  = longint'(shadow_cfg.param_d);
    lo = longint'($signed(shadow_cfg.range_low));
    hi = longint'($signed(shadow_cfg.range_high));
    case (shadow_cfg.shape_type)
      SHAPE_SINGLETON: begin
        if (x != a) return 0;
        h = b * 128;
        if (h < 0) return 0;
        if (h > 32768) return 32768;
        return h;
      end
      SHAPE_TRIANGLE: begin
        dx_abs = (x < a) ? a - x : x - a;
        if (b <= 0) return 0;
        num = b - 2 * dx_abs;
        if (num <= 0) return 0;
        return (num * 32768) / b;
      end
      SHAPE_TRAPEZOID: begin
        if (x < a - c || x >= b + d) return 0;
        if (x < a) return ((c + x - a) * 32768) / c;
        if (x < b) return 32768;
        return ((d - x + b) * 32768) / d;
      end
      default: begin
        if (x < lo || x > hi) return 0;
        k = 0;
        if (hi > lo) k = (eff_samples() * (x - lo)) / (hi - lo);
        if (k > eff_samples() - 1) k = eff_samples() - 1;
        return longint'(shadow_table[k]);
      end
    endcase
  endfunction

  function automatic longint sample_membership(input longint k);
    if (shadow_cfg.shape_type == SHAPE_TABLE) return longint'(shadow_table[k]);
    return shape_membership(sample_abscissa(k));
  endfunction

  task automatic predict_result(input fuzzy_req_t it);
    fuzzy_rsp_t r;
    longint n, m, best, best_i, num, den;
    r = '{memb: '0, crisp: '0, no_mass: 1'b0};
    n = eff_samples();
    case (it.req)
      REQ_EVAL: r.memb = 16'(shape_membership(longint'(it.x)));
      REQ_WRITE: begin
        if (shadow_cfg.shape_type == SHAPE_TABLE && longint'(it.idx) < n)
          shadow_table[it.idx] = (it.val > ONE_Q15) ? ONE_Q15 : it.val;
      end
      REQ_DEFUZZ: begin
        defuzz_count++;
        if (it.method == METHOD_FIRST_MAX) begin
          best = 0;
          best_i = 0;
          for (longint i = 0; i < n; i++) begin
            m = sample_membership(i);
            if (m > best) begin
              best = m;
              best_i = i;
            end
          end
          r.crisp = 16'(sample_abscissa(best_i));
        end else begin
          num = 0;
          den = 0;
          for (longint i = 0; i < n; i++) begin
            m = sample_membership(i);
            num += sample_abscissa(i) * m;
            den += m;
          end
          if (den == 0) r.no_mass = 1'b1;
          else r.crisp = 16'(floor_quot(num, den));
        end
      end
      default: ;
    endcase
    expected_results.push_back(r);
  endtask

  // ------------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_result(on_bus);
        items_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() > 0 &&
            ((items_taken >= 500 && items_taken < 700) || $urandom_range(99) >= 35)) begin
          on_bus = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {7'd0, on_bus.method, on_bus.val, on_bus.idx, on_bus.x};
          in_tuser  <= on_bus.req;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------ monitor
  always @(posedge clk) begin
    fuzzy_rsp_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = expected_results.pop_front();
          if (out_tdata[15:0] !== e.memb)
            report_mismatch($sformatf("membership %h, want %h", out_tdata[15:0], e.memb));
          if (out_tdata[31:16] !== e.crisp)
            report_mismatch($sformatf("crisp_x %h, want %h", out_tdata[31:16], e.crisp));
          if (out_tuser !== e.no_mass)
            report_mismatch($sformatf("no_mass %b, want %b", out_tuser, e.no_mass));
        end
        results_seen++;
        // long receiver hold-off so the core backs up onto its input
        if (results_seen == 150) hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= (results_seen >= 500 && results_seen < 700) ||
                      $urandom_range(99) >= 35;
      end
    end
  end

  // -------------------------------------------------------------- stimulus
  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_SHAPE_TYPE:   shadow_cfg.shape_type   = value[1:0];
      REG_PARAM_A:      shadow_cfg.param_a      = value[15:0];
      REG_PARAM_B:      shadow_cfg.param_b      = value[15:0];
      REG_PARAM_C:      shadow_cfg.param_c      = value[14:0];
      REG_PARAM_D:      shadow_cfg.param_d      = value[14:0];
      REG_RANGE_LOW:    shadow_cfg.range_low    = value[15:0];
      REG_RANGE_HIGH:   shadow_cfg.range_high   = value[15:0];
      default:          shadow_cfg.sample_count = value[8:0];
    endcase
  endtask

  task automatic queue_item(input logic [1:0] req, input logic [15:0] x,
                            input logic [7:0] idx, input logic [15:0] val,
                            input logic method);
    fuzzy_req_t it;
    it = '{req: req, x: x, idx: idx, val: val, method: method};
    pending_items.push_back(it);
  endtask

  // sender stays quiet until every expected result is back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() > 0 || in_tvalid || expected_results.size() > 0);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_edge16();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] lo, hi, t;
    logic [8:0]  cnt;
    longint      n;
    int          roll;
    shadow_cfg = '{shape_type: SHAPE_TRIANGLE, param_a: 16'sd0, param_b: 16'sd256,
                   param_c: 15'd256, param_d: 15'd256, range_low: -16'sd256,
                   range_high: 16'sd256, sample_count: 9'd256};
    foreach (shadow_table[i]) shadow_table[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: reset shape, x extremes, unused request, ignored write, both defuzzify methods
    queue_item(REQ_EVAL, 16'h8000, 8'd0, 16'd0, 1'b0);
    queue_item(REQ_EVAL, 16'h7fff, 8'hff, 16'hffff, 1'b1);
    queue_item(REQ_EVAL, 16'h0000, 8'd0, 16'd0, 1'b0);
    queue_item(REQ_EVAL, 16'h0080, 8'd0, 16'd0, 1'b0);
    queue_item(REQ_EVAL, 16'hff81, 8'd0, 16'd0, 1'b0);
    queue_item(2'd3, 16'hffff, 8'hff, 16'hffff, 1'b1);
    queue_item(REQ_WRITE, 16'd0, 8'd3, 16'h1234, 1'b0);
    queue_item(REQ_DEFUZZ, 16'd0, 8'd0, 16'd0, METHOD_FIRST_MAX);
    queue_item(REQ_DEFUZZ, 16'd0, 8'd0, 16'd0, METHOD_COG);
    wait_drained();

    // Directed: table shape at full length, saturated and edge entries
    write_register(REG_SHAPE_TYPE, SHAPE_TABLE);
    queue_item(REQ_DEFUZZ, 16'd0, 8'd0, 16'd0, METHOD_COG);  // empty table, no mass
    queue_item(REQ_WRITE, 16'd0, 8'd0, 16'hffff, 1'b0);
    queue_item(REQ_WRITE, 16'd0, 8'd255, 16'h8000, 1'b0);
    queue_item(REQ_WRITE, 16'd0, 8'd128, 16'h4000, 1'b0);
    queue_item(REQ_EVAL, 16'hff00, 8'd0, 16'd0, 1'b0);
    queue_item(REQ_EVAL, 16'h0100, 8'd0, 16'd0, 1'b0);       // index clamps to N-1
    queue_item(REQ_EVAL, 16'h0000, 8'd0, 16'd0, 1'b0);
    queue_item(REQ_EVAL, 16'h0101, 8'd0, 16'd0, 1'b0);       // outside the range
    queue_item(REQ_DEFUZZ, 16'd0, 8'd0, 16'd0, METHOD_FIRST_MAX);
    wait_drained();

    // Directed: count 0 saturates to 1, write past N ignored, zero span range
    write_register(REG_SAMPLE_COUNT, 32'd0);
    write_register(REG_RANGE_LOW, 32'h0000_0040);
    write_register(REG_RANGE_HIGH, 32'h0000_0040);
    queue_item(REQ_WRITE, 16'd0, 8'd1, 16'h7777, 1'b0);
    queue_item(REQ_EVAL, 16'h0040, 8'd0, 16'd0, 1'b0);
    queue_item(REQ_DEFUZZ, 16'd0, 8'd0, 16'd0, METHOD_COG);
    queue_item(REQ_WRITE, 16'd0, 8'd0, 16'd0, 1'b0);
    queue_item(REQ_DEFUZZ, 16'd0, 8'd0, 16'd0, METHOD_COG);  // zero mass
    wait_drained();

    // Randomized phases, each with a new register setting
    for (int phase = 0; phase < 30; phase++) begin
      if (phase == 1) begin
        // extremes of every register
        write_register(REG_SHAPE_TYPE, SHAPE_TRAPEZOID);
        write_register(REG_PARAM_A, 32'h0000_8000);
        write_register(REG_PARAM_B, 32'h0000_7fff);
        write_register(REG_PARAM_C, 32'h0000_7fff);
        write_register(REG_PARAM_D, 32'h0000_0000);
        write_register(REG_RANGE_LOW, 32'h0000_8000);
        write_register(REG_RANGE_HIGH, 32'h0000_7fff);
        write_register(REG_SAMPLE_COUNT, 32'h0000_01ff);
      end else begin
        write_register(REG_SHAPE_TYPE, $urandom_range(3));
        write_register(REG_PARAM_A, {16'($urandom), pick_edge16()});
        write_register(REG_PARAM_B, {16'($urandom), pick_edge16()});
        t = ($urandom_range(3) == 0) ? pick_edge16() : 16'($urandom_range(2048));
        write_register(REG_PARAM_C, {16'($urandom), t});
        t = ($urandom_range(3) == 0) ? pick_edge16() : 16'($urandom_range(2048));
        write_register(REG_PARAM_D, {16'($urandom), t});
        lo = pick_edge16();
        hi = pick_edge16();
        if ($urandom_range(3) != 0 && $signed(lo) > $signed(hi)) begin
          t = lo;
          lo = hi;
          hi = t;
        end
        write_register(REG_RANGE_LOW, {16'($urandom), lo});
        write_register(REG_RANGE_HIGH, {16'($urandom), hi});
        cnt = ($urandom_range(4) == 0) ? 9'($urandom) : 9'($urandom_range(16));
        write_register(REG_SAMPLE_COUNT, {23'($urandom), cnt});
      end
      n = eff_samples();
      // table mode: fill the first used entries (at most 24) so lookups see real data
      if (shadow_cfg.shape_type == SHAPE_TABLE)
        for (longint i = 0; i < n && i < 24; i++)
          queue_item(REQ_WRITE, 16'($urandom), 8'(i), 16'($urandom_range(36000)),
                     1'($urandom));
      for (int k = 0; k < 45; k++) begin
        roll = $urandom_range(99);
        if (roll < 8 && (n <= 32 || $urandom_range(9) == 0))
          queue_item(REQ_DEFUZZ, 16'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
        else if (roll < 25)
          queue_item(REQ_WRITE, 16'($urandom), 8'($urandom_range(n < 256 ? n + 2 : 255)),
                     ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(32768)),
                     1'($urandom));
        else if (roll < 29)
          queue_item(2'd3, 16'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
        else if (roll < 60)
          queue_item(REQ_EVAL, 16'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
        else
          // points near the shape's corners
          queue_item(REQ_EVAL,
                     ($urandom_range(1) == 0 ? shadow_cfg.param_a : shadow_cfg.param_b)
                       + 16'($signed(9'($urandom))),
                     8'($urandom), 16'($urandom), 1'($urandom));
      end
      wait_drained();
    end

    $display("covered %0d items, %0d results, %0d defuzzify requests over 33 settings",
             items_taken, results_seen, defuzz_count);
    if (error_count == 0)
      $display("fuzzy_membership_defuzzifier_core_tb: done, clean");
    else
      $display("fuzzy_membership_defuzzifier_core_tb: done, errors");
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("timeout waiting for results");
    $display("fuzzy_membership_defuzzifier_core_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+hw/rtl
hw/rtl/fmd_pkg.sv
hw/rtl/fmd_ram.sv
hw/rtl/fmd_cfg.sv
hw/rtl/fmd_div.sv
hw/rtl/fuzzy_membership_defuzzifier_core.sv
bench/fuzzy_membership_defuzzifier_core_tb.sv
